FILE: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, request and result types, and inter-cell records for the
// point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;

	// Coordinate differences and their products.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int LEN_W  = PROD_W;
	localparam int MAG_W  = PROD_W;
	localparam int HALF_W = MAG_W / 2;

	// Scaled squared distance, its root and the long-division numerator.
	localparam int QW     = 2 * COORD_BITS + 4 + 2 * FRAC_BITS;
	localparam int ROOT_W = QW / 2;
	localparam int RREM_W = ROOT_W + 2;
	localparam int NUM_W  = 2 * MAG_W + 2 * FRAC_BITS;
	localparam int DIST_W = COORD_BITS + FRAC_BITS + 1;

	localparam int FRONT_STAGES = 5;
	localparam int PSD_LATENCY  = FRONT_STAGES + QW + ROOT_W;

	typedef enum logic [1:0] {
		CASE_INSIDE = 2'd0,
		CASE_START  = 2'd1,
		CASE_END    = 2'd2
	} psd_case_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} psd_req_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [1:0]        nearest_case;
	} psd_res_t;

	// Record passed between divider cells.
	typedef struct packed {
		logic             valid;
		psd_case_t        ncase;
		logic [LEN_W-1:0] rem;
		logic [LEN_W-1:0] den;
		logic [QW-1:0]    word;
	} psd_div_t;

	// Record passed between square-root cells.
	typedef struct packed {
		logic              valid;
		psd_case_t         ncase;
		logic [QW-1:0]     rad;
		logic [RREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
	} psd_sqrt_t;

endpackage

FILE: rtl/core/point_segment_distance_top.sv
// ----------------------------------------------------------------------------
// point_segment_distance_top
// Distance from a point to a 2D segment, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  request   start / busy       request (psd_req_t)
//  result    done (one cycle)   result  (psd_res_t)
//
// A request is taken every cycle; busy is always low.
// The chain has 5 front-end stages, 52 divider cells and 26 root cells.
// Reset clears valid bits and chain records; front-end data is not reset.
// Results leave at the pipeline's pace and cannot be held off.
module point_segment_distance_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  psd_pkg::psd_req_t request,
	output logic              done,
	output psd_pkg::psd_res_t result
);
	import psd_pkg::*;

	psd_div_t  div_chain  [0:QW];
	psd_sqrt_t sqrt_chain [0:ROOT_W];

	assign busy = 1'b0;

	psd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(start),
		.request (request),
		.div_out (div_chain[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_div
		psd_div_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (div_chain[i]),
			.dout  (div_chain[i+1])
		);
	end

	always_comb begin
		sqrt_chain[0].valid = div_chain[QW].valid;
		sqrt_chain[0].ncase = div_chain[QW].ncase;
		sqrt_chain[0].rad   = div_chain[QW].word;
		sqrt_chain[0].rem   = '0;
		sqrt_chain[0].root  = '0;
	end

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.din   (sqrt_chain[j]),
			.dout  (sqrt_chain[j+1])
		);
	end

	assign done                = sqrt_chain[ROOT_W].valid;
	assign result.distance     = sqrt_chain[ROOT_W].root[DIST_W-1:0];
	assign result.nearest_case = sqrt_chain[ROOT_W].ncase;

endmodule

FILE: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Differences, dot and cross products, case decision and the division
// operands that feed the divider cells.
// ----------------------------------------------------------------------------
module psd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  psd_pkg::psd_req_t request,
	output psd_pkg::psd_div_t div_out
);
	import psd_pkg::*;

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, vx_s1, vy_s1, wx_s1, wy_s1;
	logic signed [PROD_W-1:0] dxdx_s2, dydy_s2, vxdx_s2, vydy_s2, vxdy_s2, vydx_s2;
	logic signed [PROD_W-1:0] vxvx_s2, vyvy_s2, wxwx_s2, wywy_s2;
	psd_case_t                case_s3, case_s4;
	logic [LEN_W-1:0]         len_s3, len_s4;
	logic [MAG_W-1:0]         cmag_s3;
	logic [SUM_W-1:0]         endsq_s3, endsq_s4;
	logic [2*HALF_W-1:0]      hh_s4, hl_s4, ll_s4;

	logic signed [SUM_W-1:0]  len_c, t_c, cross_c, vv_c, ww_c;
	logic [SUM_W-1:0]         cabs_c;
	psd_case_t                case_c;
	logic [2*MAG_W-1:0]       sq_c;
	logic [NUM_W-1:0]         num_c;

	always_comb begin
		len_c   = SUM_W'(dxdx_s2) + SUM_W'(dydy_s2);
		t_c     = SUM_W'(vxdx_s2) + SUM_W'(vydy_s2);
		cross_c = SUM_W'(vxdy_s2) - SUM_W'(vydx_s2);
		vv_c    = SUM_W'(vxvx_s2) + SUM_W'(vyvy_s2);
		ww_c    = SUM_W'(wxwx_s2) + SUM_W'(wywy_s2);
		cabs_c  = cross_c[SUM_W-1] ? SUM_W'(-cross_c) : SUM_W'(cross_c);
		// A zero-length segment or a foot on or before the start picks the start.
		if (len_c == '0 || t_c[SUM_W-1] || t_c == '0) begin
			case_c = CASE_START;
		end else if (t_c >= len_c) begin
			case_c = CASE_END;
		end else begin
			case_c = CASE_INSIDE;
		end
	end

	always_comb begin
		sq_c = ((2*MAG_W)'(hh_s4) << (2*HALF_W)) + ((2*MAG_W)'(hl_s4) << (HALF_W+1))
			+ (2*MAG_W)'(ll_s4);
		if (case_s4 == CASE_INSIDE) begin
			num_c = NUM_W'(sq_c) << (2*FRAC_BITS);
		end else begin
			num_c = NUM_W'(endsq_s4) << (2*FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			div_out <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			div_out.valid <= v_s4;
			// The start and end cases divide by one, so the radicand passes through unchanged.
			div_out.ncase <= case_s4;
			div_out.rem   <= LEN_W'(num_c[NUM_W-1:QW]);
			div_out.word  <= num_c[QW-1:0];
			div_out.den   <= (case_s4 == CASE_INSIDE) ? len_s4 : LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(request.end_x) - DIFF_W'(request.start_x);
		dy_s1 <= DIFF_W'(request.end_y) - DIFF_W'(request.start_y);
		vx_s1 <= DIFF_W'(request.point_x) - DIFF_W'(request.start_x);
		vy_s1 <= DIFF_W'(request.point_y) - DIFF_W'(request.start_y);
		wx_s1 <= DIFF_W'(request.point_x) - DIFF_W'(request.end_x);
		wy_s1 <= DIFF_W'(request.point_y) - DIFF_W'(request.end_y);

		dxdx_s2 <= dx_s1 * dx_s1;
		dydy_s2 <= dy_s1 * dy_s1;
		vxdx_s2 <= vx_s1 * dx_s1;
		vydy_s2 <= vy_s1 * dy_s1;
		vxdy_s2 <= vx_s1 * dy_s1;
		vydx_s2 <= vy_s1 * dx_s1;
		vxvx_s2 <= vx_s1 * vx_s1;
		vyvy_s2 <= vy_s1 * vy_s1;
		wxwx_s2 <= wx_s1 * wx_s1;
		wywy_s2 <= wy_s1 * wy_s1;

		case_s3  <= case_c;
		len_s3   <= LEN_W'(len_c);
		cmag_s3  <= MAG_W'(cabs_c);
		endsq_s3 <= (case_c == CASE_END) ? ww_c : vv_c;

		// The cross product is squared as three half-width products.
		case_s4  <= case_s3;
		len_s4   <= len_s3;
		endsq_s4 <= endsq_s3;
		hh_s4 <= cmag_s3[MAG_W-1:HALF_W] * cmag_s3[MAG_W-1:HALF_W];
		hl_s4 <= cmag_s3[MAG_W-1:HALF_W] * cmag_s3[HALF_W-1:0];
		ll_s4 <= cmag_s3[HALF_W-1:0] * cmag_s3[HALF_W-1:0];
	end

endmodule

FILE: rtl/core/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring-division step: brings in one numerator bit and produces one
// quotient bit.
// ----------------------------------------------------------------------------
module psd_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  psd_pkg::psd_div_t din,
	output psd_pkg::psd_div_t dout
);
	import psd_pkg::*;

	logic [LEN_W:0]   trial;
	logic             ge;
	logic [LEN_W:0]   diff;

	always_comb begin
		trial = {din.rem, din.word[QW-1]};
		ge    = trial >= {1'b0, din.den};
		diff  = trial - {1'b0, din.den};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.ncase <= din.ncase;
			dout.den   <= din.den;
			dout.rem   <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
			dout.word  <= {din.word[QW-2:0], ge};
		end
	end

endmodule

FILE: rtl/core/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square-root step: takes two radicand bits and produces
// one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  psd_pkg::psd_sqrt_t din,
	output psd_pkg::psd_sqrt_t dout
);
	import psd_pkg::*;

	logic [RREM_W+1:0] cur;
	logic [RREM_W+1:0] trial;
	logic              ge;
	logic [RREM_W+1:0] diff;

	always_comb begin
		cur   = {din.rem, din.rad[QW-1:QW-2]};
		trial = (RREM_W+2)'({din.root, 2'b01});
		ge    = cur >= trial;
		diff  = cur - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout.valid <= din.valid;
			dout.ncase <= din.ncase;
			dout.rad   <= din.rad << 2;
			dout.rem   <= ge ? diff[RREM_W-1:0] : cur[RREM_W-1:0];
			dout.root  <= {din.root[ROOT_W-2:0], ge};
		end
	end

endmodule

FILE: rtl/core/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks on the distance pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input psd_pkg::psd_res_t result
);
	import psd_pkg::*;

	// Every request yields a result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PSD_LATENCY done)
		else $error("request produced no result");

	// No result appears without a request at the matching earlier cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PSD_LATENCY))
		else $error("result without request");

	// The pipeline never refuses a request.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// The case code is always one of the three defined codes.
	a_case_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.nearest_case == CASE_INSIDE || result.nearest_case == CASE_START
			|| result.nearest_case == CASE_END))
		else $error("bad case code");

endmodule

bind point_segment_distance_top psd_checker u_psd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

FILE: bench/point_segment_distance_top_test.sv
// ----------------------------------------------------------------------------
// point_segment_distance_top_test
// Checks the point-to-segment distance pipeline against an exact predictor.
// A directed table covers the extremes and each case, then random requests
// follow under several idling patterns for the sender.
// ----------------------------------------------------------------------------
module point_segment_distance_top_test;
	import psd_pkg::*;

	localparam int N_RANDOM = 600;
	localparam int DRAIN    = 120;

	typedef struct {
		psd_req_t req;
		logic     known;
		psd_res_t res;
	} row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	psd_req_t request = '0;
	logic     busy;
	logic     done;
	psd_res_t result;

	psd_res_t pending[$];
	int       errors = 0;
	int       idle_pct = 0;

	point_segment_distance_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	initial begin
		#50000000;
		$display("[point_segment_distance_top] ERROR");
		$finish;
	end

	function automatic logic [127:0] isqrt128(logic [127:0] x);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= x)
				r = c;
		end
		return 128'(r);
	endfunction

	// Exact integer distance, floored to FRAC_BITS fraction bits.
	function automatic psd_res_t seg_distance(psd_req_t q);
		longint dx, dy, vx, vy, len2, proj, cr, wx, wy;
		logic [127:0] sq;
		psd_res_t r;
		dx = longint'(q.end_x) - longint'(q.start_x);
		dy = longint'(q.end_y) - longint'(q.start_y);
		vx = longint'(q.point_x) - longint'(q.start_x);
		vy = longint'(q.point_y) - longint'(q.start_y);
		len2 = dx * dx + dy * dy;
		proj = vx * dx + vy * dy;
		if (len2 == 0 || proj <= 0) begin
			sq = 128'(vx * vx + vy * vy) << (2 * FRAC_BITS);
			r.nearest_case = CASE_START;
		end else if (proj >= len2) begin
			wx = longint'(q.point_x) - longint'(q.end_x);
			wy = longint'(q.point_y) - longint'(q.end_y);
			sq = 128'(wx * wx + wy * wy) << (2 * FRAC_BITS);
			r.nearest_case = CASE_END;
		end else begin
			cr = vx * dy - vy * dx;
			if (cr < 0)
				cr = -cr;
			sq = ((128'(cr) * 128'(cr)) << (2 * FRAC_BITS)) / 128'(len2);
			r.nearest_case = CASE_INSIDE;
		end
		r.distance = DIST_W'(isqrt128(sq));
		return r;
	endfunction

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 40)) - 16'sd20;
			default: return 16'($urandom);
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	// with start still high, so requests can follow back to back.
	task automatic send(psd_req_t q, psd_res_t exp_res);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		request <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending.push_back(exp_res);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				psd_res_t e;
				e = pending.pop_front();
				if (e.distance !== result.distance || e.nearest_case !== result.nearest_case) begin
					$display("%0t: expected %h/%0d, actual %h/%0d", $time, e.distance,
						e.nearest_case, result.distance, result.nearest_case);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t table_rows[$];
		psd_req_t q;
		psd_res_t e;
		int waited;
		// Fields: point, start, end; distance typed in only where obvious.
		table_rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, CASE_START}});
		table_rows.push_back('{'{3, 4, 0, 0, 0, 0}, 1, '{25'd5 << 8, CASE_START}});
		table_rows.push_back('{'{-3, 0, 0, 0, 10, 0}, 1, '{25'd3 << 8, CASE_START}});
		table_rows.push_back('{'{13, 4, 0, 0, 10, 0}, 1, '{25'd5 << 8, CASE_END}});
		table_rows.push_back('{'{5, 7, 0, 0, 10, 0}, 1, '{25'd7 << 8, CASE_INSIDE}});
		table_rows.push_back('{'{-6, 5, 0, 0, 0, 10}, 1, '{25'd6 << 8, CASE_INSIDE}});
		table_rows.push_back('{'{0, 9, 0, 0, 0, 10}, 1, '{0, CASE_INSIDE}});
		table_rows.push_back('{'{0, 10, 0, 0, 0, 10}, 1, '{0, CASE_END}});
		table_rows.push_back('{'{0, 4, 0, 0, 10, 0}, 1, '{25'd4 << 8, CASE_START}});
		table_rows.push_back('{'{10, 4, 0, 0, 10, 0}, 1, '{25'd4 << 8, CASE_END}});
		table_rows.push_back('{'{1, 0, 0, 0, 1, 1}, 0, '0});
		table_rows.push_back('{'{-32768, -32768, 32767, 32767, 32767, 32767}, 0, '0});
		table_rows.push_back('{'{32767, -32768, -32768, 32767, -32768, 32767}, 0, '0});
		table_rows.push_back('{'{32767, 32767, -32768, -32768, 32767, -32768}, 0, '0});
		table_rows.push_back('{'{-32768, 32767, -32768, -32768, 32767, 32767}, 0, '0});
		table_rows.push_back('{'{0, 0, -32768, 32767, 32767, -32768}, 0, '0});
		table_rows.push_back('{'{-32768, -32768, 32767, -32768, -32768, 32767}, 0, '0});
		table_rows.push_back('{'{1, 2, -5, 3, 7, -11}, 0, '0});
		table_rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 1, '{0, CASE_START}});
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) begin
			q = table_rows[i].req;
			e = table_rows[i].known ? table_rows[i].res : seg_distance(q);
			send(q, e);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3)
				idle_pct = 86;
			else if (n == 2 * N_RANDOM / 3)
				idle_pct = 0;
			else if (n < N_RANDOM / 3)
				idle_pct = 20;
			if (n == N_RANDOM / 2) begin
				// Let the pipeline empty completely before continuing.
				start <= 1'b0;
				while (pending.size() != 0)
					@(negedge clk);
			end
			q.point_x = rand_coord();
			q.point_y = rand_coord();
			q.start_x = rand_coord();
			q.start_y = rand_coord();
			if ($urandom_range(0, 9) == 0) begin
				q.end_x = q.start_x;
				q.end_y = q.start_y;
			end else begin
				q.end_x = ($urandom_range(0, 5) == 0) ? q.start_x : rand_coord();
				q.end_y = ($urandom_range(0, 5) == 0) ? q.start_y : rand_coord();
			end
			send(q, seg_distance(q));
		end
		start <= 1'b0;
		waited = 0;
		while (pending.size() != 0 && waited < 10 * PSD_LATENCY) begin
			@(negedge clk);
			waited++;
		end
		repeat (DRAIN) @(negedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("[point_segment_distance_top] OK");
		else
			$display("[point_segment_distance_top] ERROR");
		$finish;
	end

endmodule
